// ===== rtl/slot_statistics_table_core_macros.svh =====
// Assertion macros for the slot statistics table checker.
`ifndef SLOT_STATISTICS_TABLE_CORE_MACROS_SVH
`define SLOT_STATISTICS_TABLE_CORE_MACROS_SVH

// Checked while reset is low.
`define SST_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("slot statistics table check failed");

// Checked at every edge, reset included.
`define SST_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("slot statistics table reset check failed");

`endif

// ===== rtl/sst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

  localparam int DEFAULT_SLOT_COUNT = 1024;

  localparam logic [2:0] REQ_REGISTER  = 3'd0;
  localparam logic [2:0] REQ_ADD_TICKS = 3'd1;
  localparam logic [2:0] REQ_ADD_SIZE  = 3'd2;
  localparam logic [2:0] REQ_CLEAR     = 3'd3;
  localparam logic [2:0] REQ_QUERY     = 3'd4;

  localparam int KIND_TICKS = 0;
  localparam int KIND_SIZE  = 1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [9:0]  slot;
    logic [1:0]  kinds;
    logic [30:0] amount;
  } in_req_t;

  typedef struct packed {
    logic        status;
    logic [47:0] tick_total;
    logic [30:0] tick_max;
    logic [31:0] tick_num;
    logic [47:0] total_size;
    logic [31:0] size_count;
  } out_rsp_t;

  typedef struct packed {
    logic [1:0]  kinds;
    logic [47:0] tick_sum;
    logic [30:0] tick_peak;
    logic [31:0] tick_adds;
    logic [47:0] size_sum;
    logic [31:0] size_adds;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic wr_en;
    logic hw_raise;
  } upd_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/sst_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/sst_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sst_alu import sst_pkg::*; #(
  parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT
) (
  input  wire in_req_t                          req,
  input  wire entry_t                           rd,
  input  wire logic [$clog2(SLOT_COUNT+1)-1:0]  high_water,
  input  wire logic                             clr_walk,
  output entry_t                                wr,
  output upd_ctl_t                              ctl,
  output out_rsp_t                              rsp,
  output logic      [$clog2(SLOT_COUNT+1)-1:0]  hw_next
);

  localparam int HW = $clog2(SLOT_COUNT + 1);

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [30:0] b);
    logic [48:0] s;
    s = {1'b0, a} + 49'(b);
    return s[48] ? '1 : s[47:0];
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] a);
    return (a == '1) ? a : a + 32'd1;
  endfunction

  logic        in_range;
  logic        below_hw;
  logic [31:0] slot_p1;
  logic        status;

  assign in_range = 32'(req.slot) < 32'(SLOT_COUNT);
  assign below_hw = 32'(req.slot) < 32'(high_water);
  assign slot_p1  = 32'(req.slot) + 32'd1;
  assign hw_next  = HW'(slot_p1);

  always_comb begin
    wr     = rd;
    ctl    = '0;
    rsp    = '0;
    status = 1'b1;
    if (clr_walk) begin
      ctl.wr_en = 1'b1;
      if (rd.kinds[KIND_TICKS]) begin
        wr.tick_sum  = '0;
        wr.tick_peak = '0;
        wr.tick_adds = '0;
      end
      if (rd.kinds[KIND_SIZE]) begin
        wr.size_sum  = '0;
        wr.size_adds = '0;
      end
    end else begin
      case (req.req_type)
        REQ_REGISTER: begin
          if (in_range && req.kinds != 2'b00 && rd.kinds == 2'b00) begin
            wr           = '0;
            wr.kinds     = req.kinds;
            ctl.wr_en    = 1'b1;
            ctl.hw_raise = slot_p1 > 32'(high_water);
            status       = 1'b0;
          end
        end
        REQ_ADD_TICKS: begin
          if (in_range && below_hw && rd.kinds[KIND_TICKS]) begin
            wr.tick_sum  = sat_add48(rd.tick_sum, req.amount);
            wr.tick_adds = sat_inc32(rd.tick_adds);
            if (req.amount > rd.tick_peak) begin
              wr.tick_peak = req.amount;
            end
            ctl.wr_en = 1'b1;
            status    = 1'b0;
          end
        end
        REQ_ADD_SIZE: begin
          if (in_range && below_hw && rd.kinds[KIND_SIZE]) begin
            wr.size_sum  = sat_add48(rd.size_sum, req.amount);
            wr.size_adds = sat_inc32(rd.size_adds);
            ctl.wr_en    = 1'b1;
            status       = 1'b0;
          end
        end
        REQ_CLEAR: begin
          status = 1'b0;
        end
        REQ_QUERY: begin
          if (in_range && below_hw) begin
            rsp.tick_total = rd.tick_sum;
            rsp.tick_max   = rd.tick_peak;
            rsp.tick_num   = rd.tick_adds;
            rsp.total_size = rd.size_sum;
            rsp.size_count = rd.size_adds;
            status         = 1'b0;
          end
        end
        default: begin
          status = 1'b1;
        end
      endcase
    end
    rsp.status = status;
  end

endmodule

`default_nettype wire

// ===== rtl/slot_statistics_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Slot statistics table. Requests arrive on req (valid/ready) and each one
// yields exactly one result on rsp (valid/ready), in order.
// All slot state lives in one RAM of SLOT_COUNT entries with a registered read;
// each request reads its slot; register and add requests that succeed write it back.
// Register, add, query and unknown requests are held in req_q, read their slot
// and present their result once the output register is free; req_ready returns
// as the result is loaded, so one request is in the block at a time.
// A clear request walks the slots below the high-water mark, reading each slot
// in ST_CLR_RD and writing it back in ST_CLR_WR; its result is presented from
// ST_CLR_END once the output register is free. When the high-water mark is zero
// it skips the walk and presents its result like the requests above.
// After reset the RAM is zeroed one entry per cycle, with req_ready low throughout.
// The result is held in an output register: a new request is accepted while
// a result still waits, and only the completion of the following request waits
// for rsp_ready, with the result held stable until it is taken.

module slot_statistics_table_core import sst_pkg::*; #(
  parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire in_req_t  req,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output out_rsp_t      rsp
);

  localparam int AW = $clog2(SLOT_COUNT);
  localparam int HW = $clog2(SLOT_COUNT + 1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLR_RD,
    ST_CLR_WR,
    ST_CLR_END
  } state_t;

  state_t        state;
  in_req_t       req_q;
  logic [AW-1:0] cnt;
  logic [HW-1:0] high_water;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  entry_t        wr_data;
  entry_t        rd_data;

  entry_t        alu_wr;
  upd_ctl_t      alu_ctl;
  out_rsp_t      alu_rsp;
  logic [HW-1:0] hw_next;

  logic          out_free;
  logic          exec_walk;
  logic          init_last;
  logic          clr_last;
  logic          rsp_load;

  assign req_ready = (state == ST_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;
  assign exec_walk = (req_q.req_type == REQ_CLEAR) && (high_water != '0);
  assign init_last = (cnt == AW'(SLOT_COUNT - 1));
  assign clr_last  = (HW'(cnt) + HW'(1)) == high_water;
  assign rsp_load  = out_free && ((state == ST_EXEC && !exec_walk) || state == ST_CLR_END);

  always_comb begin
    case (state)
      ST_IDLE:   rd_addr = AW'(req.slot);
      ST_EXEC:   rd_addr = AW'(req_q.slot);
      default:   rd_addr = cnt;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_data = alu_wr;
    case (state)
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      ST_EXEC: begin
        wr_addr = AW'(req_q.slot);
        wr_en   = alu_ctl.wr_en && out_free && !exec_walk;
      end
      ST_CLR_WR: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  sst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  sst_alu #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_alu (
    .req        (req_q),
    .rd         (rd_data),
    .high_water (high_water),
    .clr_walk   (state == ST_CLR_WR),
    .wr         (alu_wr),
    .ctl        (alu_ctl),
    .rsp        (alu_rsp),
    .hw_next    (hw_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      cnt        <= '0;
      high_water <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          if (init_last) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_walk) begin
            cnt   <= '0;
            state <= ST_CLR_RD;
          end else if (out_free) begin
            rsp <= alu_rsp;
            if (alu_ctl.hw_raise) begin
              high_water <= hw_next;
            end
            state <= ST_IDLE;
          end
        end
        ST_CLR_RD: begin
          state <= ST_CLR_WR;
        end
        ST_CLR_WR: begin
          if (clr_last) begin
            cnt   <= '0;
            state <= ST_CLR_END;
          end else begin
            cnt   <= cnt + AW'(1);
            state <= ST_CLR_RD;
          end
        end
        ST_CLR_END: begin
          if (out_free) begin
            rsp   <= '0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_INIT;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sst_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "slot_statistics_table_core_macros.svh"

module sst_checker import sst_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     req_valid,
  input wire logic     req_ready,
  input wire logic     rsp_valid,
  input wire logic     rsp_ready,
  input wire out_rsp_t rsp
);

  `SST_ASSERT_RST(a_reset_quiet, rst |=> !req_ready && !rsp_valid)

  `SST_ASSERT(a_one_in_flight, req_valid && req_ready |=> !req_ready)

  `SST_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))

  `SST_ASSERT(a_reject_zero, rsp_valid && rsp.status |-> rsp[$bits(out_rsp_t)-2:0] == '0)

endmodule

bind slot_statistics_table_core sst_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire

// ===== bench/slot_statistics_table_checker.sv =====
`timescale 1ns / 1ps

module slot_statistics_table_checker import sst_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  input  wire logic     req_ready,
  input  wire in_req_t  req,
  input  wire logic     rsp_valid,
  input  wire logic     rsp_ready,
  input  wire out_rsp_t rsp,
  output int            mismatches,
  output int            outstanding
);

  localparam int SLOTS = DEFAULT_SLOT_COUNT;

  entry_t      stats_tab [SLOTS];
  int unsigned high_water;
  out_rsp_t    awaited_rsp [$];
  int          fault_count;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    fault_count++;
  endtask

  function automatic out_rsp_t apply_request(input in_req_t r);
    out_rsp_t    o;
    entry_t      e;
    logic [48:0] s;
    int          i;
    o = '0;
    o.status = 1'b1;
    e = stats_tab[r.slot];
    case (r.req_type)
      REQ_REGISTER: begin
        if (r.kinds != 2'b00 && e.kinds == 2'b00) begin
          e = '0;
          e.kinds = r.kinds;
          stats_tab[r.slot] = e;
          if (int'(r.slot) + 1 > high_water) begin
            high_water = int'(r.slot) + 1;
          end
          o.status = 1'b0;
        end
      end
      REQ_ADD_TICKS: begin
        if (r.slot < high_water && e.kinds[KIND_TICKS]) begin
          s = {1'b0, e.tick_sum} + r.amount;
          e.tick_sum = s[48] ? '1 : s[47:0];
          if (e.tick_adds != '1) begin
            e.tick_adds = e.tick_adds + 32'd1;
          end
          if (r.amount > e.tick_peak) begin
            e.tick_peak = r.amount;
          end
          stats_tab[r.slot] = e;
          o.status = 1'b0;
        end
      end
      REQ_ADD_SIZE: begin
        if (r.slot < high_water && e.kinds[KIND_SIZE]) begin
          s = {1'b0, e.size_sum} + r.amount;
          e.size_sum = s[48] ? '1 : s[47:0];
          if (e.size_adds != '1) begin
            e.size_adds = e.size_adds + 32'd1;
          end
          stats_tab[r.slot] = e;
          o.status = 1'b0;
        end
      end
      REQ_CLEAR: begin
        for (i = 0; i < high_water && i < SLOTS; i++) begin
          if (stats_tab[i].kinds[KIND_TICKS]) begin
            stats_tab[i].tick_sum = '0;
            stats_tab[i].tick_peak = '0;
            stats_tab[i].tick_adds = '0;
          end
          if (stats_tab[i].kinds[KIND_SIZE]) begin
            stats_tab[i].size_sum = '0;
            stats_tab[i].size_adds = '0;
          end
        end
        o.status = 1'b0;
      end
      REQ_QUERY: begin
        if (r.slot < high_water) begin
          o.tick_total = e.tick_sum;
          o.tick_max = e.tick_peak;
          o.tick_num = e.tick_adds;
          o.total_size = e.size_sum;
          o.size_count = e.size_adds;
          o.status = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    out_rsp_t want;
    if (rst) begin
      foreach (stats_tab[k]) begin
        stats_tab[k] = '0;
      end
      high_water = 0;
      awaited_rsp.delete();
      fault_count = 0;
    end else begin
      if (req_valid && req_ready) begin
        awaited_rsp.push_back(apply_request(req));
      end
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          report_mismatch("result with no request outstanding", 64'(rsp.status), 64'd0);
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.status !== want.status) begin
            report_mismatch("status", 64'(rsp.status), 64'(want.status));
          end
          if (rsp.tick_total !== want.tick_total) begin
            report_mismatch("tick_total", 64'(rsp.tick_total), 64'(want.tick_total));
          end
          if (rsp.tick_max !== want.tick_max) begin
            report_mismatch("tick_max", 64'(rsp.tick_max), 64'(want.tick_max));
          end
          if (rsp.tick_num !== want.tick_num) begin
            report_mismatch("tick_num", 64'(rsp.tick_num), 64'(want.tick_num));
          end
          if (rsp.total_size !== want.total_size) begin
            report_mismatch("total_size", 64'(rsp.total_size), 64'(want.total_size));
          end
          if (rsp.size_count !== want.size_count) begin
            report_mismatch("size_count", 64'(rsp.size_count), 64'(want.size_count));
          end
        end
      end
    end
    mismatches <= fault_count;
    outstanding <= awaited_rsp.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import sst_pkg::*;

  localparam int RANDOM_REQUESTS = 1900;
  localparam int POOL_SIZE = 32;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  in_req_t  req = '0;
  logic     rsp_ready = 1'b0;
  logic     req_ready;
  logic     rsp_valid;
  out_rsp_t rsp;
  int       mismatches;
  int       outstanding;
  int       sent_total = 0;
  int       burst_left = 0;
  logic [9:0] slot_pool [POOL_SIZE];

  slot_statistics_table_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  slot_statistics_table_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic in_req_t make_request(input logic [2:0] kind, input int slot,
                                           input logic [1:0] kinds, input logic [30:0] amount);
    in_req_t r;
    r.req_type = kind;
    r.slot = 10'(slot);
    r.kinds = kinds;
    r.amount = amount;
    return r;
  endfunction

  function automatic in_req_t random_request();
    in_req_t r;
    int      pick;
    r.kinds = 2'($urandom_range(3));
    r.slot = ($urandom_range(99) < 85) ? slot_pool[$urandom_range(POOL_SIZE - 1)]
                                       : 10'($urandom_range(1023));
    case ($urandom_range(9))
      0, 1, 2: r.amount = 31'($urandom);
      3, 4:    r.amount = 31'($urandom_range(1000));
      5:       r.amount = '1;
      6:       r.amount = '0;
      default: r.amount = 31'($urandom_range(1000000));
    endcase
    pick = $urandom_range(99);
    if (pick < 14) begin
      r.req_type = REQ_REGISTER;
    end else if (pick < 44) begin
      r.req_type = REQ_ADD_TICKS;
    end else if (pick < 74) begin
      r.req_type = REQ_ADD_SIZE;
    end else if (pick < 76) begin
      r.req_type = REQ_CLEAR;
    end else if (pick < 96) begin
      r.req_type = REQ_QUERY;
    end else begin
      r.req_type = 3'($urandom_range(7, 5));
    end
    return r;
  endfunction

  // The sender offers requests in bursts; a gap of idle cycles follows each burst.
  task automatic issue(input in_req_t r);
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent_total++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      burst_left = $urandom_range(24);
    end
  endtask

  initial begin : stimulus
    in_req_t directed [$];
    int      n;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    directed.push_back(make_request(REQ_CLEAR, 0, 2'd0, 31'd0));
    directed.push_back(make_request(REQ_QUERY, 0, 2'd0, 31'd0));
    directed.push_back(make_request(REQ_ADD_TICKS, 0, 2'd1, 31'd7));
    directed.push_back(make_request(REQ_REGISTER, 0, 2'd0, 31'd0));
    directed.push_back(make_request(REQ_REGISTER, 0, 2'd1, 31'd0));
    directed.push_back(make_request(REQ_REGISTER, 0, 2'd3, 31'd0));
    directed.push_back(make_request(REQ_ADD_TICKS, 3, 2'd0, 31'd4));
    directed.push_back(make_request(REQ_REGISTER, 1023, 2'd3, 31'd0));
    directed.push_back(make_request(REQ_QUERY, 500, 2'd0, 31'd0));
    directed.push_back(make_request(REQ_ADD_TICKS, 500, 2'd0, 31'd10));
    directed.push_back(make_request(REQ_ADD_TICKS, 0, 2'd0, '1));
    directed.push_back(make_request(REQ_ADD_TICKS, 0, 2'd0, 31'd0));
    directed.push_back(make_request(REQ_ADD_SIZE, 0, 2'd0, 31'd9));
    directed.push_back(make_request(REQ_ADD_SIZE, 1023, 2'd0, '1));
    directed.push_back(make_request(REQ_ADD_TICKS, 1023, 2'd0, 31'd5));
    directed.push_back(make_request(REQ_REGISTER, 2, 2'd2, 31'd0));
    directed.push_back(make_request(REQ_ADD_TICKS, 2, 2'd0, 31'd3));
    directed.push_back(make_request(REQ_ADD_SIZE, 2, 2'd0, 31'd1));
    directed.push_back(make_request(REQ_QUERY, 0, 2'd0, 31'd0));
    directed.push_back(make_request(REQ_QUERY, 1023, 2'd0, 31'd0));
    directed.push_back(make_request(REQ_CLEAR, 0, 2'd0, 31'd0));
    directed.push_back(make_request(REQ_QUERY, 0, 2'd0, 31'd0));
    directed.push_back(make_request(REQ_QUERY, 1023, 2'd0, 31'd0));
    for (n = 5; n <= 7; n++) begin
      directed.push_back(make_request(3'(n), 1023, 2'd3, '1));
    end
    foreach (directed[k]) begin
      issue(directed[k]);
    end

    foreach (slot_pool[k]) begin
      slot_pool[k] = 10'($urandom_range(1023));
    end
    slot_pool[0] = 10'd0;
    slot_pool[1] = 10'd1023;
    slot_pool[2] = 10'd2;
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      issue(random_request());
    end
    req_valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS slot_statistics_table_core");
    end else begin
      $display("FAIL slot_statistics_table_core");
    end
    $finish;
  end

  // The receiver picks a new stall rate after each run of random ready values and, once, holds
  // off for a long stretch so that the table backs up into the request side.
  initial begin : rsp_side
    int stall_pct;
    bit held_off;
    held_off = 1'b0;
    forever begin
      case ($urandom_range(2))
        0:       stall_pct = 0;
        1:       stall_pct = 30;
        default: stall_pct = 70;
      endcase
      repeat ($urandom_range(80, 10)) begin
        @(posedge clk);
        rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
      if (!held_off && sent_total >= 600) begin
        held_off = 1'b1;
        @(posedge clk);
        rsp_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #15_000_000;
    $display("FAIL slot_statistics_table_core");
    $finish;
  end

endmodule
